>>> design/fcwa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcwa_pkg
// Shared widths, types, register indexes and helpers for the four channel
// window averager.
// ----------------------------------------------------------------------------
package fcwa_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int NUM_CH     = 4;
	localparam int CH_W       = $clog2(NUM_CH);
	localparam int MAX_WINDOW = 1024;
	localparam int ADDR_W     = $clog2(MAX_WINDOW);
	localparam int LEN_W      = ADDR_W + 1;
	localparam int SUM_W      = SAMPLE_W + ADDR_W;
	localparam int DIV_CNT_W  = $clog2(SUM_W);
	localparam int SLOT_W     = NUM_CH * SAMPLE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LEN_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [LEN_W-1:0]           len_t;
	typedef logic [ADDR_W-1:0]          addr_t;
	typedef logic [SLOT_W-1:0]          slot_t;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTH = CFG_IDX_W'(1);

	localparam len_t LEN_RESET = LEN_W'(64);

	typedef struct packed {
		logic  start;
		sum_t  dividend;
		len_t  divisor;
	} div_req_t;

	typedef struct packed {
		logic    done;
		sample_t quotient;
	} div_rsp_t;

	// zero means one slot, anything past the memory depth saturates
	function automatic len_t eff_len(input logic [CFG_DATA_W-1:0] v);
		len_t r;
		if (v == '0) begin
			r = LEN_W'(1);
		end else if (v > CFG_DATA_W'(MAX_WINDOW)) begin
			r = LEN_W'(MAX_WINDOW);
		end else begin
			r = LEN_W'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/four_channel_window_averager_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_channel_window_averager_core
// Boxcar moving average over four signed Q16.16 channels with bypass mode.
// ----------------------------------------------------------------------------
// Each accepted word carries four samples; in averaging mode the block writes
// them into one ring slot of a 1024 x 128 bit window RAM, updates four 42 bit
// running sums with a read-modify-write of that slot, and returns the sum of
// each channel divided by window_length, truncated toward zero (slots not yet
// filled count as zero). Before the next word can be taken, an averaging
// word goes through these steps: the RAM read is issued with the
// acceptance, then the sum update, one division per channel in the one
// shared bit-serial divider, which sets the rate, the load of the output
// register and the return to idle. A bypass word goes straight to the
// output register load. The result sits in an output register, so a new
// word is accepted while the previous result is still stalled; the block
// only waits longer when a finished result finds the output register still
// stalled. Any write to a known register clears the window directly (a wrap
// flag masks slots not yet written), so no clearing pass is needed and
// cfg_ready is always high. Configure only while no word is in flight.
// ----------------------------------------------------------------------------
module four_channel_window_averager_core import fcwa_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  sample_valid,
	output logic                       sample_stall,
	input  wire sample_t               pressure_sample,
	input  wire sample_t               temperature_sample,
	input  wire sample_t               fused_height_sample,
	input  wire sample_t               baro_height_sample,
	output logic                       mean_valid,
	input  wire logic                  mean_stall,
	output sample_t                    mean_pressure,
	output sample_t                    mean_temperature,
	output sample_t                    mean_fused_height,
	output sample_t                    mean_baro_height
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_UPDATE    = 3'd1;
	localparam logic [2:0] ST_DIV_START = 3'd2;
	localparam logic [2:0] ST_DIV_WAIT  = 3'd3;
	localparam logic [2:0] ST_OUT       = 3'd4;

	logic [2:0]      state_q;
	logic            avg_en_q;
	len_t            len_q;
	addr_t           ring_q;
	logic            wrapped_q;
	logic [CH_W-1:0] ch_q;
	sum_t            sums_q [NUM_CH];
	sample_t         smp_q  [NUM_CH];
	sample_t         res_q  [NUM_CH];
	sample_t         out_q  [NUM_CH];
	logic            out_valid_q;

	sample_t  smp_in  [NUM_CH];
	sample_t  old_smp [NUM_CH];
	sum_t     sums_nxt[NUM_CH];
	logic     cfg_wr;
	logic     cfg_clear;
	logic     accept;
	logic     out_load;
	logic     ram_re;
	logic     ram_we;
	slot_t    ram_wdata;
	slot_t    ram_rdata;
	len_t     ring_inc;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign smp_in[0] = pressure_sample;
	assign smp_in[1] = temperature_sample;
	assign smp_in[2] = fused_height_sample;
	assign smp_in[3] = baro_height_sample;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign cfg_clear = cfg_wr & ((cfg_index == CFG_IDX_ENABLE) || (cfg_index == CFG_IDX_LENGTH));

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid & ~sample_stall;
	assign out_load     = (state_q == ST_OUT) & (~out_valid_q | ~mean_stall);

	assign ram_re   = accept & avg_en_q;
	assign ram_we   = (state_q == ST_UPDATE);
	assign ring_inc = {1'b0, ring_q} + LEN_W'(1);

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			// before the first wrap the slot at the ring index was never written
			old_smp[ch]  = wrapped_q ? sample_t'(ram_rdata[ch*SAMPLE_W +: SAMPLE_W]) : '0;
			sums_nxt[ch] = sums_q[ch]
				- {{ADDR_W{old_smp[ch][SAMPLE_W-1]}}, old_smp[ch]}
				+ {{ADDR_W{smp_q[ch][SAMPLE_W-1]}}, smp_q[ch]};
		end
		ram_wdata = {smp_q[3], smp_q[2], smp_q[1], smp_q[0]};
	end

	assign div_req.start    = (state_q == ST_DIV_START);
	assign div_req.dividend = sums_q[ch_q];
	assign div_req.divisor  = len_q;

	fcwa_ram #(
		.DATA_W(SLOT_W),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ring_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ring_q),
		.rdata(ram_rdata)
	);

	fcwa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			avg_en_q    <= 1'b1;
			len_q       <= LEN_RESET;
			ring_q      <= '0;
			wrapped_q   <= 1'b0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				sums_q[ch] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (~mean_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= avg_en_q ? ST_UPDATE : ST_OUT;
					end
				end
				ST_UPDATE: begin
					for (int ch = 0; ch < NUM_CH; ch++) begin
						sums_q[ch] <= sums_nxt[ch];
					end
					if (ring_inc >= len_q) begin
						ring_q    <= '0;
						wrapped_q <= 1'b1;
					end else begin
						ring_q <= ring_inc[ADDR_W-1:0];
					end
					ch_q    <= '0;
					state_q <= ST_DIV_START;
				end
				ST_DIV_START: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (ch_q == CH_W'(NUM_CH - 1)) begin
							state_q <= ST_OUT;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= ST_DIV_START;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_clear) begin
				ring_q    <= '0;
				wrapped_q <= 1'b0;
				for (int ch = 0; ch < NUM_CH; ch++) begin
					sums_q[ch] <= '0;
				end
				if (cfg_index == CFG_IDX_ENABLE) begin
					avg_en_q <= cfg_data[0];
				end else begin
					len_q <= eff_len(cfg_data);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				smp_q[ch] <= smp_in[ch];
				res_q[ch] <= smp_in[ch];
			end
		end
		if ((state_q == ST_DIV_WAIT) && div_rsp.done) begin
			res_q[ch_q] <= div_rsp.quotient;
		end
		if (out_load) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				out_q[ch] <= res_q[ch];
			end
		end
	end

	assign mean_valid        = out_valid_q;
	assign mean_pressure     = out_q[0];
	assign mean_temperature  = out_q[1];
	assign mean_fused_height = out_q[2];
	assign mean_baro_height  = out_q[3];

endmodule
`default_nettype wire

>>> design/fcwa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcwa_ram
// Simple dual port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fcwa_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/fcwa_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcwa_div
// Shared radix-2 restoring divider: signed running sum over unsigned window
// length, quotient truncated toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcwa_div import fcwa_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [SUM_W-1:0]     quo_q;
	logic [LEN_W-1:0]     rem_q;
	len_t                 div_q;

	logic [LEN_W:0]   shifted;
	logic [LEN_W+1:0] diff;
	logic             qbit;
	sample_t          q_low;

	always_comb begin
		shifted = {rem_q, quo_q[SUM_W-1]};
		diff    = {1'b0, shifted} - {2'b00, div_q};
		qbit    = ~diff[LEN_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[SUM_W-1];
			quo_q <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], qbit};
			rem_q <= qbit ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
		end
	end

	// mean always fits the sample width, so only the low bits are kept
	assign q_low        = quo_q[SAMPLE_W-1:0];
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -q_low : q_low;

endmodule
`default_nettype wire

>>> design/fcwa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcwa_checker
// Port level checks for the window averager: input busy after acceptance,
// results only for outstanding words, occupancy and output hold under stall.
// ----------------------------------------------------------------------------
module fcwa_checker import fcwa_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    sample_valid,
	input wire logic    sample_stall,
	input wire logic    mean_valid,
	input wire logic    mean_stall,
	input wire sample_t mean_pressure,
	input wire sample_t mean_temperature,
	input wire sample_t mean_fused_height,
	input wire sample_t mean_baro_height
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pending_q;

	assign in_acc  = sample_valid & ~sample_stall;
	assign out_acc = mean_valid & ~mean_stall;

	// words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 2'd1;
		end else if (!in_acc && out_acc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> sample_stall)
		else $error("input taken again right after a word was accepted");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		mean_valid |-> (pending_q != 2'd0))
		else $error("result shown with no word outstanding");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (pending_q == 2'd0 || pending_q == 2'd1))
		else $error("word accepted with two words already outstanding");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mean_valid && mean_stall |=> mean_valid && $stable(mean_pressure)
			&& $stable(mean_temperature) && $stable(mean_fused_height)
			&& $stable(mean_baro_height))
		else $error("stalled result changed");

endmodule

bind four_channel_window_averager_core fcwa_checker u_fcwa_checker (.*);
`default_nettype wire
